// ===== src/fftd_pkg.sv =====
`timescale 1ns / 1ps

package fftd_pkg;

	// Frame layout
	localparam logic [7:0] SYNC_A = 8'hAF;
	localparam logic [7:0] SYNC_B = 8'hFA;
	localparam logic [7:0] SYNC_C = 8'h55;
	localparam logic [7:0] END_A  = 8'h77;
	localparam logic [7:0] END_B  = 8'hAA;

	localparam int FRAME_LEN  = 18;
	localparam int PAYLOAD_AT = 3;
	localparam int POS_W      = 5;

	// Positions where the tracker makes a decision (count of bytes held before the new byte)
	localparam logic [POS_W-1:0] POS_SYNC_LAST  = POS_W'(PAYLOAD_AT - 1);
	localparam logic [POS_W-1:0] POS_FRAME_LAST = POS_W'(FRAME_LEN - 1);

	// History line: newest byte at index 0; when the last frame byte arrives,
	// entry k holds frame byte (FRAME_LEN - 2 - k)
	localparam int HIST_DEPTH = FRAME_LEN - 1 - PAYLOAD_AT;

	// Decoded frame contents
	typedef struct packed {
		logic [7:0]         steering;
		logic [7:0]         thr_request;
		logic [7:0]         thr_applied;
		logic [7:0]         brake_level;
		logic signed [31:0] speed;
		logic [7:0]         pwm_first;
		logic [7:0]         pwm_second;
		logic [15:0]        distance;
		logic [7:0]         sampling_rate;
	} fftd_result_t;

	// Tracker state seen by the top level
	typedef struct packed {
		logic             in_frame;
		logic [POS_W-1:0] pos;
	} fftd_status_t;

endpackage

// ===== src/fftd_tracker.sv =====
`timescale 1ns / 1ps

module fftd_tracker import fftd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  logic [7:0]   rx_byte,
	output logic         emit,
	output fftd_result_t result,
	output fftd_status_t status
);

	logic             in_frame_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       hist_q [HIST_DEPTH];

	logic             in_frame_d;
	logic [POS_W-1:0] pos_d;
	logic             sync_bad;
	logic             frame_end;

	// Frame checks on the byte now arriving
	assign sync_bad  = in_frame_q && (pos_q == POS_SYNC_LAST)
		&& !((hist_q[0] == SYNC_B) && (rx_byte == SYNC_C));
	assign frame_end = in_frame_q && (pos_q == POS_FRAME_LAST);
	assign emit      = frame_end && (hist_q[0] == END_A) && (rx_byte == END_B);

	// Next frame state
	always_comb begin
		in_frame_d = in_frame_q;
		pos_d      = pos_q;
		if (!in_frame_q) begin
			if (rx_byte == SYNC_A) begin
				in_frame_d = 1'b1;
				pos_d      = POS_W'(1);
			end
		end else if (sync_bad || frame_end) begin
			in_frame_d = 1'b0;
			pos_d      = '0;
		end else begin
			pos_d = pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
		end else if (fire) begin
			in_frame_q <= in_frame_d;
			pos_q      <= pos_d;
		end
	end

	// Byte history; only entries of the current frame are ever used
	always_ff @(posedge clk) begin
		if (fire) begin
			hist_q[0] <= rx_byte;
			for (int i = 1; i < HIST_DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	// Payload byte p sits at hist_q[HIST_DEPTH - 1 - p] when the last byte arrives
	assign result.steering      = hist_q[HIST_DEPTH-1];
	assign result.thr_request   = hist_q[HIST_DEPTH-2];
	assign result.thr_applied   = hist_q[HIST_DEPTH-3];
	assign result.brake_level   = hist_q[HIST_DEPTH-4];
	assign result.speed         = {hist_q[HIST_DEPTH-8], hist_q[HIST_DEPTH-7],
		hist_q[HIST_DEPTH-6], hist_q[HIST_DEPTH-5]};
	assign result.pwm_first     = hist_q[HIST_DEPTH-9];
	assign result.pwm_second    = hist_q[HIST_DEPTH-10];
	assign result.distance      = {hist_q[HIST_DEPTH-12], hist_q[HIST_DEPTH-11]};
	assign result.sampling_rate = hist_q[HIST_DEPTH-13];

	assign status.in_frame = in_frame_q;
	assign status.pos      = pos_q;

endmodule

// ===== src/fixed_frame_telemetry_deframer_core.sv =====
`timescale 1ns / 1ps

// Telemetry deframer: accepts one received byte per cycle and hunts for 18-byte
// frames (sync AF FA 55, thirteen payload bytes, end 77 AA). A frame whose sync
// and end bytes check out yields one result carrying the decoded payload; bad
// frames are dropped without a result. Throughput is one byte per clock; the
// frame tracker lies between the input and result registers, and a result is
// registered once its final byte passes from the input register through the
// tracker. While a result waits on out_stall, further bytes are still taken;
// only a byte that completes another good frame waits for the slot.

module fixed_frame_telemetry_deframer_core import fftd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         steering,
	output logic [7:0]         thr_request,
	output logic [7:0]         thr_applied,
	output logic [7:0]         brake_level,
	output logic signed [31:0] speed,
	output logic [7:0]         pwm_first,
	output logic [7:0]         pwm_second,
	output logic [15:0]        distance,
	output logic [7:0]         sampling_rate
);

	logic         valid_s1;
	logic [7:0]   rx_byte_s1;
	logic         fire;
	logic         emit;
	logic         slot_free;
	fftd_result_t result;
	fftd_result_t result_q;
	fftd_status_t status;
	logic         out_valid_q;

	// Stage 1 moves on unless it finishes a good frame while the result is held
	assign slot_free = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && (!emit || slot_free);
	assign in_stall  = valid_s1 && !fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	fftd_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (rx_byte_s1),
		.emit    (emit),
		.result  (result),
		.status  (status)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			result_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign steering      = result_q.steering;
	assign thr_request   = result_q.thr_request;
	assign thr_applied   = result_q.thr_applied;
	assign brake_level   = result_q.brake_level;
	assign speed         = result_q.speed;
	assign pwm_first     = result_q.pwm_first;
	assign pwm_second    = result_q.pwm_second;
	assign distance      = result_q.distance;
	assign sampling_rate = result_q.sampling_rate;

	// Checks
	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!status.in_frame |-> (status.pos == '0))
		else $error("position not cleared while hunting");

	a_frame_pos: assert property (@(posedge clk) disable iff (!arst_n)
		status.in_frame |-> ((status.pos != '0) && (status.pos <= POS_FRAME_LAST)))
		else $error("position out of frame range");

	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit) |=> out_valid)
		else $error("good frame did not reach the result register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !(fire && emit))
		else $error("held result overwritten");

endmodule
